FILE: rtl/core/lctm_pkg.sv
// Shared types and constants for the load-cell tare median servo goal block.
package lctm_pkg;

  localparam int SUM_W   = 26;
  localparam int NET_W   = 25;
  localparam int SPAN_W  = 21;
  localparam int GOAL_W  = 13;
  localparam int QUO_W   = 14;
  localparam int PROD_W  = NET_W + SPAN_W;
  localparam int NUM_W   = PROD_W + 2;
  localparam int CNT_W   = 5;
  localparam int CFG_W   = 25;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_Q8    = 2'd1;

  localparam logic [NET_W-1:0]  MAX_WEIGHT_RST = 25'd360000;
  localparam logic [SPAN_W-1:0] SPAN_Q8_RST    = 21'd189326;
  localparam logic [GOAL_W-1:0] GOAL_MAX       = 13'd8191;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SEL_V,
    ST_SEL_LATCH,
    ST_SEL_SCAN,
    ST_SEL_DRAIN,
    ST_SEL_CHECK,
    ST_NET,
    ST_MUL,
    ST_DIV_PRE,
    ST_DIV,
    ST_OUT
  } lctm_state_t;

  typedef struct packed {
    logic load_in;
    logic push;
    logic sel_read;
    logic sel_latch;
    logic scan;
    logic sel_next;
    logic sel_take;
    logic net_init;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } lctm_cmd_t;

  typedef struct packed {
    logic capture;
    logic scan_last;
    logic found;
    logic step_last;
    logic out_busy;
  } lctm_sts_t;

endpackage

FILE: rtl/core/lctm_ctrl.sv
// Sequencer for push, rank select, scaling and result hand-off.
module lctm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  lctm_pkg::lctm_sts_t sts,
  output lctm_pkg::lctm_cmd_t cmd,
  output logic                in_stall
);
  import lctm_pkg::*;

  lctm_state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_PUSH;
      ST_PUSH:      state_next = sts.capture ? ST_SEL_V : ST_NET;
      ST_SEL_V:     state_next = ST_SEL_LATCH;
      ST_SEL_LATCH: state_next = ST_SEL_SCAN;
      ST_SEL_SCAN:  if (sts.scan_last) state_next = ST_SEL_DRAIN;
      ST_SEL_DRAIN: state_next = ST_SEL_CHECK;
      ST_SEL_CHECK: state_next = sts.found ? ST_NET : ST_SEL_V;
      ST_NET:       state_next = ST_MUL;
      ST_MUL:       if (sts.step_last) state_next = ST_DIV_PRE;
      ST_DIV_PRE:   state_next = ST_DIV;
      ST_DIV:       if (sts.step_last) state_next = ST_OUT;
      ST_OUT:       if (!sts.out_busy) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_PUSH:      cmd.push = 1'b1;
      ST_SEL_V:     cmd.sel_read = 1'b1;
      ST_SEL_LATCH: cmd.sel_latch = 1'b1;
      ST_SEL_SCAN:  cmd.scan = 1'b1;
      ST_SEL_DRAIN: cmd = '0;
      ST_SEL_CHECK: begin
        cmd.sel_take = sts.found;
        cmd.sel_next = !sts.found;
      end
      ST_NET:       cmd.net_init = 1'b1;
      ST_MUL:       cmd.mul_step = 1'b1;
      ST_DIV_PRE:   cmd.div_init = 1'b1;
      ST_DIV:       cmd.div_step = 1'b1;
      ST_OUT:       cmd.out_load = !sts.out_busy;
      default:      cmd = '0;
    endcase
  end

endmodule

FILE: rtl/core/lctm_dp.sv
// Datapath: sum window, rank select counters, net weight, serial scaler.
module lctm_dp #(
  parameter int WINDOW_DEPTH = 20,
  parameter int CELL_WIDTH   = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lctm_pkg::lctm_cmd_t                    cmd,
  output lctm_pkg::lctm_sts_t                    sts,
  input  logic signed [CELL_WIDTH-1:0]           cell_a,
  input  logic signed [CELL_WIDTH-1:0]           cell_b,
  input  logic signed [CELL_WIDTH-1:0]           cell_c,
  input  logic signed [CELL_WIDTH-1:0]           cell_d,
  input  logic                                   capture_tare,
  input  logic                                   cfg_we,
  input  logic [lctm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lctm_pkg::CFG_W-1:0]             cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [lctm_pkg::SUM_W-1:0]      gross_sum,
  output logic signed [lctm_pkg::SUM_W-1:0]      tare_out,
  output logic [lctm_pkg::NET_W-1:0]             net_weight,
  output logic [lctm_pkg::GOAL_W-1:0]            goal_position,
  output logic                                   ready_res
);
  import lctm_pkg::*;

  localparam int CntW  = $clog2(WINDOW_DEPTH + 1);
  localparam int AddrW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int ExtW  = (CELL_WIDTH + 2 > SUM_W) ? CELL_WIDTH + 2 : SUM_W;
  localparam logic [CntW:0] Depth = (CntW + 1)'(WINDOW_DEPTH);

  logic signed [SUM_W-1:0] mem [WINDOW_DEPTH];
  logic signed [SUM_W-1:0] rd_data;
  logic [AddrW-1:0]        rd_addr;

  logic [CntW-1:0]         win_count, oldest, sel_i, scan_j, less_cnt, eq_cnt;
  logic signed [SUM_W-1:0] tare, gross, cand;
  logic                    capture, cmp_en;
  logic [NET_W-1:0]        max_weight;
  logic [SPAN_W-1:0]       span_q8;
  logic [NET_W-1:0]        net;
  logic [PROD_W-1:0]       net_sh, acc;
  logic [SPAN_W-1:0]       mreg;
  logic [NUM_W-1:0]        rem;
  logic [NUM_W-2:0]        dsh;
  logic [QUO_W-1:0]        quo;
  logic [CNT_W-1:0]        cnt;

  logic signed [ExtW-1:0]  sum_ext;
  logic [CntW:0]           slot_raw, slot;
  logic [CntW-1:0]         half;
  logic signed [SUM_W:0]   diff;
  logic [NET_W-1:0]        net_comb;
  logic [GOAL_W-1:0]       goal_comb;

  // Sum the readings, wrap to the sum width
  assign sum_ext = ExtW'(cell_a) + ExtW'(cell_b) + ExtW'(cell_c) + ExtW'(cell_d);

  // Write slot after the newest entry; over the oldest once the window is full
  assign slot_raw = {1'b0, oldest} + {1'b0, win_count};
  assign slot     = (slot_raw >= Depth) ? slot_raw - Depth : slot_raw;

  assign half = win_count >> 1;
  assign rd_addr = cmd.scan ? scan_j[AddrW-1:0] : sel_i[AddrW-1:0];

  // Window memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.push) mem[slot[AddrW-1:0]] <= gross;
    if (cmd.sel_read || cmd.scan) rd_data <= mem[rd_addr];
  end

  // Net weight: zero without tare, floor at zero, clamp to max_weight
  assign diff = {gross[SUM_W-1], gross} - {tare[SUM_W-1], tare};
  always_comb begin
    if (tare == '0 || diff[SUM_W] || diff == '0) net_comb = '0;
    else if (diff[SUM_W-1:0] > {1'b0, max_weight}) net_comb = max_weight;
    else net_comb = diff[NET_W-1:0];
  end

  // Saturate the quotient; zero without tare or with max_weight zero
  always_comb begin
    if (tare == '0 || max_weight == '0) goal_comb = '0;
    else if (quo[QUO_W-1]) goal_comb = GOAL_MAX;
    else goal_comb = quo[GOAL_W-1:0];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      win_count  <= '0;
      oldest     <= '0;
      tare       <= '0;
      max_weight <= MAX_WEIGHT_RST;
      span_q8    <= SPAN_Q8_RST;
      out_valid  <= 1'b0;
      cmp_en     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_WEIGHT: max_weight <= cfg_data[NET_W-1:0];
          REG_SPAN_Q8:    span_q8 <= cfg_data[SPAN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.push) begin
        if ({1'b0, win_count} < Depth) win_count <= win_count + 1'b1;
        else if ({1'b0, oldest} == Depth - 1'b1) oldest <= '0;
        else oldest <= oldest + 1'b1;
      end
      if (cmd.sel_take) tare <= cand;
      cmp_en <= cmd.scan;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      gross   <= sum_ext[SUM_W-1:0];
      capture <= capture_tare;
    end
    if (cmd.push) sel_i <= '0;
    if (cmd.sel_next) sel_i <= sel_i + 1'b1;
    if (cmd.sel_latch) begin
      cand     <= rd_data;
      scan_j   <= '0;
      less_cnt <= '0;
      eq_cnt   <= '0;
    end else begin
      if (cmd.scan) scan_j <= scan_j + 1'b1;
      if (cmp_en) begin
        if (rd_data < cand) less_cnt <= less_cnt + 1'b1;
        else if (rd_data == cand) eq_cnt <= eq_cnt + 1'b1;
      end
    end
    // Shift-add multiply net * span
    if (cmd.net_init) begin
      net    <= net_comb;
      net_sh <= PROD_W'(net_comb);
      mreg   <= span_q8;
      acc    <= '0;
      cnt    <= CNT_W'(SPAN_W - 1);
    end
    if (cmd.mul_step) begin
      if (mreg[0]) acc <= acc + net_sh;
      net_sh <= net_sh << 1;
      mreg   <= mreg >> 1;
      cnt    <= cnt - 1'b1;
    end
    // Restoring divide of (2*p + 256*mw) by 512*mw
    if (cmd.div_init) begin
      rem <= {1'b0, acc, 1'b0} + NUM_W'({max_weight, 8'b0});
      dsh <= (NUM_W-1)'({max_weight, 9'b0}) << (QUO_W - 1);
      quo <= '0;
      cnt <= CNT_W'(QUO_W - 1);
    end
    if (cmd.div_step) begin
      if ({1'b0, dsh} <= rem) begin
        rem <= rem - {1'b0, dsh};
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
    if (cmd.out_load) begin
      gross_sum     <= gross;
      tare_out      <= tare;
      net_weight    <= net;
      goal_position <= goal_comb;
      ready_res     <= (tare != '0);
    end
  end

  // Status back to the sequencer
  always_comb begin
    sts.capture   = capture;
    sts.scan_last = (scan_j == win_count - 1'b1);
    sts.found     = (less_cnt <= half) && (half < less_cnt + eq_cnt);
    sts.step_last = (cnt == '0);
    sts.out_busy  = out_valid && out_stall;
  end

endmodule

FILE: rtl/core/load_cell_tare_median_to_servo_goal_top.sv
// Top level: load-cell sum window, median tare and servo goal scaling.
//
// Input channel in_valid/in_stall carries four signed cell readings and a
// tare-capture flag; output channel out_valid/out_stall carries one result
// item per input item. An item is taken on a clock edge with valid high
// and stall low. in_stall is low only while the sequencer is idle.
// Without capture an accepted item passes through the push, the net step,
// the shift-add multiply, the divide setup, the restoring divide steps
// and the output load. A new item is taken only once the sequencer is
// back to idle. A capture adds a rank select after the push that scans
// all held sums for each candidate until the median candidate is found.
// The output register holds a finished item while out_stall is high; a new
// item is accepted meanwhile and waits at the output load step.
// Synchronous reset empties the window, clears tare and sets max_weight
// and span_q8 to their defaults. The user makes configuration writes on
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module load_cell_tare_median_to_servo_goal_top #(
  parameter int WINDOW_DEPTH = 20,
  parameter int CELL_WIDTH   = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [CELL_WIDTH-1:0]      cell_a,
  input  logic signed [CELL_WIDTH-1:0]      cell_b,
  input  logic signed [CELL_WIDTH-1:0]      cell_c,
  input  logic signed [CELL_WIDTH-1:0]      cell_d,
  input  logic                              capture_tare,
  input  logic                              cfg_we,
  input  logic [lctm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lctm_pkg::CFG_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lctm_pkg::SUM_W-1:0] gross_sum,
  output logic signed [lctm_pkg::SUM_W-1:0] tare_out,
  output logic [lctm_pkg::NET_W-1:0]        net_weight,
  output logic [lctm_pkg::GOAL_W-1:0]       goal_position,
  output logic                              ready_res
);
  import lctm_pkg::*;

  lctm_cmd_t cmd;
  lctm_sts_t sts;

  lctm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  lctm_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .CELL_WIDTH   (CELL_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cell_a        (cell_a),
    .cell_b        (cell_b),
    .cell_c        (cell_c),
    .cell_d        (cell_d),
    .capture_tare  (capture_tare),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .gross_sum     (gross_sum),
    .tare_out      (tare_out),
    .net_weight    (net_weight),
    .goal_position (goal_position),
    .ready_res     (ready_res)
  );

  // Ready flag tracks a nonzero tare
  a_ready_tare: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ready_res == (tare_out != '0)))
    else $error("ready_res does not match tare_out");

  // No tare means no net weight and no goal
  a_no_tare_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ready_res) |-> (net_weight == '0 && goal_position == '0))
    else $error("net or goal nonzero without tare");

  // Input is held off while an item is in work
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in work");

endmodule

FILE: bench/load_cell_tare_median_to_servo_goal_top_test.sv
// Testbench for the load-cell median tare to servo goal block, with predictor and checks.
module load_cell_tare_median_to_servo_goal_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lctm_pkg::*;

  localparam int DEPTH = 20;
  localparam int CW = 24;

  typedef struct {
    logic signed [CW-1:0] a, b, c, d;
    logic cap;
  } load_sample_t;

  typedef struct {
    logic [SUM_W-1:0] gross;
    logic [SUM_W-1:0] tare;
    logic [NET_W-1:0] net;
    logic [GOAL_W-1:0] goal;
    logic ready;
  } scale_reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] cell_a = '0, cell_b = '0, cell_c = '0, cell_d = '0;
  logic capture_tare = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_WEIGHT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SUM_W-1:0] gross_sum, tare_out;
  logic [NET_W-1:0] net_weight;
  logic [GOAL_W-1:0] goal_position;
  logic ready_res;

  load_cell_tare_median_to_servo_goal_top DUT (.*);

  always #5 clk = ~clk;

  // Predictor state
  longint sums[DEPTH];
  int held_count = 0;
  int oldest = 0;
  longint tare_val = 0;
  longint unsigned mw_cfg = 360000;
  longint unsigned span_cfg = 189326;

  load_sample_t pending_samples[$];
  scale_reading_t expected_readings[$];
  int errors = 0;
  bit quiet = 0;

  function automatic int pick_gap(bit no_gaps);
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic longint median_of_window();
    int k, less, same;
    k = held_count / 2;
    for (int i = 0; i < held_count; i++) begin
      less = 0;
      same = 0;
      for (int j = 0; j < held_count; j++) begin
        if (sums[j] < sums[i]) less++;
        else if (sums[j] == sums[i]) same++;
      end
      if (less <= k && k < less + same) return sums[i];
    end
    return 0;
  endfunction

  // Push the sum, capture tare if asked, then scale to a goal
  function automatic scale_reading_t predict_scale_reading(load_sample_t s);
    scale_reading_t r;
    longint total, diff;
    longint unsigned net, goal, den;
    total = longint'(s.a) + longint'(s.b) + longint'(s.c) + longint'(s.d);
    sums[(oldest + held_count) % DEPTH] = total;
    if (held_count < DEPTH) held_count++;
    else oldest = (oldest + 1) % DEPTH;
    if (s.cap) tare_val = median_of_window();
    net = 0;
    goal = 0;
    if (tare_val != 0) begin
      diff = total - tare_val;
      net = (diff > 0) ? diff : 0;
      if (net > mw_cfg) net = mw_cfg;
      if (mw_cfg != 0) begin
        den = mw_cfg * 256;
        goal = (2 * net * span_cfg + den) / (2 * den);
        if (goal > GOAL_MAX) goal = GOAL_MAX;
      end
    end
    r.gross = total[SUM_W-1:0];
    r.tare = tare_val[SUM_W-1:0];
    r.net = net[NET_W-1:0];
    r.goal = goal[GOAL_W-1:0];
    r.ready = (tare_val != 0);
    return r;
  endfunction

  // Driver: offer pending items, hold a stalled item, idle at random
  load_sample_t cur;
  int send_gap = 0;
  always @(posedge clk) begin
    bit nvalid;
    bit took;
    scale_reading_t pred;
    took = 0;
    if (rst) begin
      nvalid = 0;
    end else begin
      if (in_valid && !in_stall) begin
        pred = predict_scale_reading(cur);
        expected_readings.insert(expected_readings.size(), pred);
        took = 1;
        send_gap = pick_gap(quiet);
      end
      if (in_valid && !took) begin
        nvalid = 1;
      end else if (send_gap > 0) begin
        send_gap--;
        nvalid = 0;
      end else if (pending_samples.size() > 0) begin
        cur = pending_samples[0];
        pending_samples.delete(0);
        nvalid = 1;
      end else begin
        nvalid = 0;
      end
    end
    in_valid <= nvalid;
    cell_a <= cur.a;
    cell_b <= cur.b;
    cell_c <= cur.c;
    cell_d <= cur.d;
    capture_tare <= cur.cap;
  end

  int results = 0;
  int recv_gap = 0;
  logic hold_off = 1'b0;

  // Hold the receiver off for a long stretch once, so the block fills and stalls
  initial begin
    wait (results >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (900) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Monitor: check each item against the oldest expectation, stall at random
  always @(posedge clk) begin
    scale_reading_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results++;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected item gross=%0d", $time, gross_sum);
          errors++;
        end else begin
          e = expected_readings[0];
          expected_readings.delete(0);
          if (gross_sum !== e.gross) begin
            $display("%0t: gross_sum exp %0d got %0d", $time, $signed(e.gross), gross_sum);
            errors++;
          end
          if (tare_out !== e.tare) begin
            $display("%0t: tare_out exp %0d got %0d", $time, $signed(e.tare), tare_out);
            errors++;
          end
          if (net_weight !== e.net) begin
            $display("%0t: net_weight exp %0d got %0d", $time, e.net, net_weight);
            errors++;
          end
          if (goal_position !== e.goal) begin
            $display("%0t: goal_position exp %0d got %0d", $time, e.goal, goal_position);
            errors++;
          end
          if (ready_res !== e.ready) begin
            $display("%0t: ready_res exp %0d got %0d", $time, e.ready, ready_res);
            errors++;
          end
        end
        recv_gap = pick_gap(quiet);
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_sample(int a, int b, int c, int d, bit cap);
    load_sample_t s;
    s.a = CW'(a);
    s.b = CW'(b);
    s.c = CW'(c);
    s.d = CW'(d);
    s.cap = cap;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  function automatic int rand_cell(int base);
    case ($urandom_range(0, 11))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 8388607 : -8388608;
      2: return 0;
      default: return base + int'($urandom_range(0, 40000)) - 20000;
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_WEIGHT) mw_cfg = val & 64'h1FF_FFFF;
    else span_cfg = val & 64'h1F_FFFF;
  endtask

  task automatic random_phase(int n, longint unsigned mw, longint unsigned span);
    int base;
    write_reg(REG_MAX_WEIGHT, mw);
    write_reg(REG_SPAN_Q8, span);
    base = $urandom_range(0, 60000) - 10000;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0)
        add_sample(0, 0, 0, 0, $urandom_range(0, 1) == 1);
      else
        add_sample(rand_cell(base), rand_cell(base), rand_cell(base), rand_cell(base),
                   $urandom_range(0, 7) == 0);
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Directed: zero median, extremes, floor, clamp, full window wrap
    add_sample(0, 0, 0, 0, 1);
    add_sample(8388607, 8388607, 8388607, 8388607, 0);
    add_sample(-8388608, -8388608, -8388608, -8388608, 1);
    add_sample(25000, 25000, 25000, 25000, 1);
    add_sample(30000, 30000, 30000, 30000, 0);
    add_sample(8388607, 8388607, 8388607, 8388607, 0);
    add_sample(-8388608, -8388608, -8388608, -8388608, 0);
    add_sample(-1, 5592405, -5592406, 1, 0);
    for (int i = 0; i < 16; i++)
      add_sample(22500 + i * 10, 22500, 22500, 22500, i == 15);
    wait_idle();
    random_phase(110, 360000, 189326);
    quiet = 1;
    random_phase(110, 1, 128);
    quiet = 0;
    random_phase(110, 33554431, 1048576);
    random_phase(110, 1, 2097151);
    quiet = 1;
    random_phase(110, 360000, 0);
    quiet = 0;
    random_phase(110, $urandom_range(1, 200000), $urandom_range(0, 1048576));
    random_phase(110, 33554431, 2097151);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("load_cell_tare_median_to_servo_goal_top_test: done, clean");
    else
      $display("load_cell_tare_median_to_servo_goal_top_test: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("load_cell_tare_median_to_servo_goal_top_test: done, errors");
    $finish;
  end
endmodule

FILE: files.f
rtl/core/lctm_pkg.sv
rtl/core/lctm_ctrl.sv
rtl/core/lctm_dp.sv
rtl/core/load_cell_tare_median_to_servo_goal_top.sv
bench/load_cell_tare_median_to_servo_goal_top_test.sv
